>>> hw/rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types for the midpoint ellipse rasterizer: datapath operation codes
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  // func field code for a start item, anything else advances one step
  localparam logic FUNC_START = 1'b0;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,      // take center and radii of a start item
    OP_SQ_RAD,     // rx * rx
    OP_SQ_RY,      // ry * ry
    OP_START_MUL,  // rx^2 * ry
    OP_START_DEC,  // region one initial decision
    OP_MOVE,       // step x and y from the decision sign
    OP_MUL_BX,     // b^2 * x
    OP_ACC_BX,     // add 2 b^2 x term and constant, start a^2 * y
    OP_ACC_AY,     // subtract 2 a^2 y term, end of step checks
    OP_T_XX,       // x * x
    OP_T_BT,       // b^2 * (x^2 + x)
    OP_T_LOAD,     // decision = b^2 (x^2 + x) + b^2/4, start (y-1)^2
    OP_T_AP,       // a^2 * (y-1)^2
    OP_T_ADD,      // add a^2 (y-1)^2, start a^2 * b^2
    OP_T_SUB       // subtract a^2 b^2
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       load;  // put a pixel into the output register
    logic [1:0] idx;   // which of the four symmetric pixels
    logic       last;  // last pixel of this item
  } dp_cmd_t;

  typedef struct packed {
    logic drawing;   // an ellipse is in progress
    logic sw;        // this step moves the walk to region two
    logic out_free;  // output register can take a pixel
  } dp_status_t;

endpackage

>>> hw/rtl/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse walk registers, one shared multiplier and the decision accumulator,
// plus the output register for plotted pixels.
// ----------------------------------------------------------------------------
module mer_datapath import mer_pkg::*; #(
  parameter int COORD_BITS  = 11,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [COORD_BITS-1:0]         center_y_i,
  input  logic [RADIUS_BITS-1:0]        radius_x_i,
  input  logic [RADIUS_BITS-1:0]        radius_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS+1:0]  pixel_x_o,
  output logic signed [COORD_BITS+1:0]  pixel_y_o,
  output logic                          last_of_run_o,
  output logic                          finished_o
);

  localparam int PIX_BITS  = COORD_BITS + 2;
  localparam int SQ_BITS   = 2 * RADIUS_BITS;
  localparam int MUL_BITS  = 2 * RADIUS_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int DEC_BITS  = 4 * RADIUS_BITS + 8;
  localparam int SUM_BITS  = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic [COORD_BITS-1:0]      org_x_q, org_y_q;
  logic [RADIUS_BITS-1:0]     rad_q;
  logic [SQ_BITS-1:0]         a2_q, b2_q;
  logic [RADIUS_BITS-1:0]     x_q, y_q;
  logic signed [DEC_BITS-1:0] dec_q, dec_d;
  logic [PROD_BITS-1:0]       prod_q, prod_d, bx_q;
  logic                       r2_q, drawing_q, br_q, fin_q;
  logic                       out_valid_q, last_q, fin_out_q;
  logic [PIX_BITS-1:0]        pix_x_q, pix_y_q;

  logic [MUL_BITS-1:0]        mul_a, mul_b, t_sum;
  logic [RADIUS_BITS-1:0]     x_sat, ym1;
  logic signed [DEC_BITS-1:0] a2_s, b2_s, a2_qtr_s, b2_qtr_s, prod_s, prod2_s;
  logic                       br, use_bx, use_ay, sw;
  logic signed [SUM_BITS-1:0] ox_s, oy_s, xs_s, ys_s, px_full, py_full;

  assign x_sat = (x_q != {RADIUS_BITS{1'b1}}) ? x_q + 1'b1 : x_q;
  assign ym1   = y_q - 1'b1;
  assign t_sum = prod_q[MUL_BITS-1:0] + {{(MUL_BITS-RADIUS_BITS){1'b0}}, x_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQ_RAD: begin
        mul_a = {{(MUL_BITS-RADIUS_BITS){1'b0}}, rad_q};
        mul_b = {{(MUL_BITS-RADIUS_BITS){1'b0}}, rad_q};
      end
      OP_SQ_RY: begin
        mul_a = {{(MUL_BITS-RADIUS_BITS){1'b0}}, y_q};
        mul_b = {{(MUL_BITS-RADIUS_BITS){1'b0}}, y_q};
      end
      OP_START_MUL, OP_ACC_BX: begin
        mul_a = {1'b0, a2_q};
        mul_b = {{(MUL_BITS-RADIUS_BITS){1'b0}}, y_q};
      end
      OP_MUL_BX: begin
        mul_a = {1'b0, b2_q};
        mul_b = {{(MUL_BITS-RADIUS_BITS){1'b0}}, x_q};
      end
      OP_T_XX: begin
        mul_a = {{(MUL_BITS-RADIUS_BITS){1'b0}}, x_q};
        mul_b = {{(MUL_BITS-RADIUS_BITS){1'b0}}, x_q};
      end
      OP_T_BT: begin
        mul_a = {1'b0, b2_q};
        mul_b = t_sum;
      end
      OP_T_LOAD: begin
        mul_a = {{(MUL_BITS-RADIUS_BITS){1'b0}}, ym1};
        mul_b = {{(MUL_BITS-RADIUS_BITS){1'b0}}, ym1};
      end
      OP_T_AP: begin
        mul_a = {1'b0, a2_q};
        mul_b = prod_q[MUL_BITS-1:0];
      end
      OP_T_ADD: begin
        mul_a = {1'b0, a2_q};
        mul_b = {1'b0, b2_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = {{MUL_BITS{1'b0}}, mul_a} * {{MUL_BITS{1'b0}}, mul_b};

  assign a2_s     = $signed({{(DEC_BITS-SQ_BITS){1'b0}}, a2_q});
  assign b2_s     = $signed({{(DEC_BITS-SQ_BITS){1'b0}}, b2_q});
  assign a2_qtr_s = $signed({{(DEC_BITS-SQ_BITS+2){1'b0}}, a2_q[SQ_BITS-1:2]});
  assign b2_qtr_s = $signed({{(DEC_BITS-SQ_BITS+2){1'b0}}, b2_q[SQ_BITS-1:2]});
  assign prod_s   = $signed({{(DEC_BITS-PROD_BITS){1'b0}}, prod_q});
  assign prod2_s  = $signed({{(DEC_BITS-PROD_BITS-1){1'b0}}, prod_q, 1'b0});

  // region one steps on d < 0, region two on d <= 0
  assign br     = r2_q ? (dec_q[DEC_BITS-1] || (dec_q == '0)) : dec_q[DEC_BITS-1];
  assign use_bx = !r2_q || br_q;
  assign use_ay = r2_q || !br_q;
  assign sw     = !r2_q && (y_q != '0) && (bx_q >= prod_q);

  always_comb begin
    dec_d = dec_q;
    unique case (cmd_i.op)
      OP_START_DEC: dec_d = b2_s - prod_s + a2_qtr_s;
      OP_ACC_BX:    dec_d = dec_q + (use_bx ? prod2_s : '0) + (r2_q ? a2_s : b2_s);
      OP_ACC_AY:    dec_d = use_ay ? dec_q - prod2_s : dec_q;
      OP_T_LOAD:    dec_d = prod_s + b2_qtr_s;
      OP_T_ADD:     dec_d = dec_q + prod_s;
      OP_T_SUB:     dec_d = dec_q - prod_s;
      default:      dec_d = dec_q;
    endcase
  end

  // pixel of the current walk point; idx bit 0 mirrors x, bit 1 mirrors y
  assign ox_s    = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, org_x_q});
  assign oy_s    = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, org_y_q});
  assign xs_s    = $signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, x_q});
  assign ys_s    = $signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, y_q});
  assign px_full = cmd_i.idx[0] ? ox_s - xs_s : ox_s + xs_s;
  assign py_full = cmd_i.idx[1] ? oy_s - ys_s : oy_s + ys_s;

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q        <= 1'b0;
      drawing_q   <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_LATCH) begin
        r2_q      <= 1'b0;
        drawing_q <= (radius_y_i != '0);
        fin_q     <= (radius_y_i == '0);
      end else if (cmd_i.op == OP_ACC_AY) begin
        drawing_q <= (y_q != '0);
        fin_q     <= (y_q == '0);
        if (sw) begin
          r2_q <= 1'b1;
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk registers and output payload
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dec_q  <= dec_d;
    unique case (cmd_i.op)
      OP_LATCH: begin
        org_x_q <= center_x_i;
        org_y_q <= center_y_i;
        rad_q   <= radius_x_i;
        x_q     <= '0;
        y_q     <= radius_y_i;
      end
      OP_SQ_RY: a2_q <= prod_q[SQ_BITS-1:0];
      OP_START_MUL: b2_q <= prod_q[SQ_BITS-1:0];
      OP_MOVE: begin
        br_q <= br;
        if (!r2_q) begin
          x_q <= x_sat;
          if (!br) begin
            y_q <= ym1;
          end
        end else begin
          y_q <= ym1;
          if (br) begin
            x_q <= x_sat;
          end
        end
      end
      OP_ACC_BX: bx_q <= prod_q;
      default: begin
      end
    endcase
    if (cmd_i.load) begin
      pix_x_q   <= px_full[PIX_BITS-1:0];
      pix_y_q   <= py_full[PIX_BITS-1:0];
      last_q    <= cmd_i.last;
      fin_out_q <= fin_q;
    end
  end

  assign status_o.drawing  = drawing_q;
  assign status_o.sw       = sw;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = $signed(pix_x_q);
  assign pixel_y_o     = $signed(pix_y_q);
  assign last_of_run_o = last_q;
  assign finished_o    = fin_out_q;

endmodule

>>> hw/rtl/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the ellipse walk: issues one datapath operation per cycle in
// its compute states and hands pixels to the output register as it frees up.
// ----------------------------------------------------------------------------
module mer_ctrl import mer_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST1, S_ST2, S_ST3, S_ST4,
    S_A2, S_A3, S_A4,
    S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] idx_q;
  logic       single_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.op   = OP_NOP;
    cmd_o.load = 1'b0;
    cmd_o.idx  = idx_q;
    cmd_o.last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_START) begin
            cmd_o.op = OP_LATCH;
          end else if (status_i.drawing) begin
            cmd_o.op = OP_MOVE;
          end
        end
      end
      S_ST1:  cmd_o.op = OP_SQ_RAD;
      S_ST2:  cmd_o.op = OP_SQ_RY;
      S_ST3:  cmd_o.op = OP_START_MUL;
      S_ST4:  cmd_o.op = OP_START_DEC;
      S_A2:   cmd_o.op = OP_MUL_BX;
      S_A3:   cmd_o.op = OP_ACC_BX;
      S_A4:   cmd_o.op = OP_ACC_AY;
      S_T1:   cmd_o.op = OP_T_XX;
      S_T2:   cmd_o.op = OP_T_BT;
      S_T3:   cmd_o.op = OP_T_LOAD;
      S_T4:   cmd_o.op = OP_T_AP;
      S_T5:   cmd_o.op = OP_T_ADD;
      S_T6:   cmd_o.op = OP_T_SUB;
      S_EMIT: begin
        cmd_o.load = status_i.out_free;
        cmd_o.last = single_q || (idx_q == 2'd3);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= 2'd0;
      single_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          idx_q <= 2'd0;
          if (in_valid_i) begin
            if (func_i == FUNC_START) begin
              state_q  <= S_ST1;
              single_q <= 1'b1;
            end else if (status_i.drawing) begin
              state_q  <= S_A2;
              single_q <= 1'b0;
            end
          end
        end
        S_ST1: state_q <= S_ST2;
        S_ST2: state_q <= S_ST3;
        S_ST3: state_q <= S_ST4;
        S_ST4: state_q <= S_EMIT;
        S_A2:  state_q <= S_A3;
        S_A3:  state_q <= S_A4;
        S_A4:  state_q <= status_i.sw ? S_T1 : S_EMIT;
        S_T1:  state_q <= S_T2;
        S_T2:  state_q <= S_T3;
        S_T3:  state_q <= S_T4;
        S_T4:  state_q <= S_T5;
        S_T5:  state_q <= S_T6;
        S_T6:  state_q <= S_EMIT;
        S_EMIT: begin
          if (status_i.out_free) begin
            if (single_q || (idx_q == 2'd3)) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Two-region integer midpoint ellipse walk, one decision step per advance.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o with func_i, center and radii.
//   func_i low starts an ellipse and yields the top point as one pixel;
//   func_i high takes one decision step and yields four mirrored pixels.
//   an advance with no ellipse in progress yields nothing.
//   output channel: out_valid_o / out_ready_i, one pixel per transfer,
//   last_of_run_o marks the final pixel of an item, finished_o flags every
//   pixel of the step that completed the ellipse.
// sequence
//   start: accept, setup (rx^2, ry^2, rx^2 * ry on the single shared
//   multiplier, then the initial decision), one pixel load. advance:
//   accept with the move, the decision update, a load for each of the four
//   pixels; on the step that enters region two the region two decision is
//   rebuilt on the multiplier before the loads. each load waits for the
//   one-pixel output register, and its pixel shows on the port next cycle.
// reset clears the walk (idle, no pending pixel). a stalled receiver holds
// the pixel in the output register; the sequencer waits, and the next item
// may be accepted while the last pixel of the previous one still waits.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int COORD_BITS  = 11,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [COORD_BITS-1:0]         center_y_i,
  input  logic [RADIUS_BITS-1:0]        radius_x_i,
  input  logic [RADIUS_BITS-1:0]        radius_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS+1:0]  pixel_x_o,
  output logic signed [COORD_BITS+1:0]  pixel_y_o,
  output logic                          last_of_run_o,
  output logic                          finished_o
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .status_i   (sts),
    .cmd_o      (cmd)
  );

  mer_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (sts),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_x_i    (radius_x_i),
    .radius_y_i    (radius_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_of_run_o (last_of_run_o),
    .finished_o    (finished_o)
  );

  // a pixel is only loaded when the output register is free
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> sts.out_free)
    else $error("pixel loaded over a waiting transfer");

  // a start always spends setup cycles before taking another item
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FUNC_START)) |=> !in_ready_o)
    else $error("start item did not occupy the sequencer");

  // mid-run pixels keep the input closed until the run ends
  a_run_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && !cmd.last) |=> !in_ready_o)
    else $error("input opened in the middle of a pixel run");

endmodule
